// File: rtl/core/als_pkg.sv
`default_nettype none

package als_pkg;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_PRELOAD = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_FLUSH   = 2'd3;

	localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
	localparam logic [1:0] REG_ZERO_LOW  = 2'd1;
	localparam logic [1:0] REG_ONE_HIGH  = 2'd2;
	localparam logic [1:0] REG_ONE_LOW   = 2'd3;

	localparam int BYTES_PER_LED = 3;
	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef struct packed {
		logic [7:0] zero_high;
		logic [7:0] zero_low;
		logic [7:0] one_high;
		logic [7:0] one_low;
	} timing_t;

	typedef struct packed {
		logic load;
		logic tick;
	} wave_ctl_t;

	typedef struct packed {
		logic sending;
		logic low;
		logic finish;
		logic rd_en;
	} wave_st_t;

	function automatic logic [7:0] phase_len(input logic one, input logic low_ph,
		input timing_t t);
		logic [7:0] v;
		if (low_ph) begin
			v = one ? t.one_low : t.zero_low;
		end else begin
			v = one ? t.one_high : t.zero_high;
		end
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/addressable_led_serializer.sv
// Serializer for a chain of addressable RGB LEDs. Preload stores one colour
// as green, red, blue bytes; flush sends the store MSB first on the chosen
// line as high/low pulses whose lengths come from the four tick registers.
// A tick, clear, or refused command is registered and shown on the next
// cycle, so ticks run one per cycle while busy is low. A preload writes its
// bytes in turn through the single write port of the colour store with busy
// high; an accepted flush passes flush_pend_q, then done, for the registered
// read of the first byte. Each result is shown for one cycle with done high
// and cannot be held off, so the receiver must take it in that cycle.
`default_nettype none

module addressable_led_serializer #(
	parameter int LED_CAPACITY = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] command,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic [2:0] pin_index,
	output logic            done,
	output logic      [7:0] line_levels,
	output logic      [7:0] drive_enable,
	output logic            busy_res,
	output logic      [6:0] led_count,
	output logic            accepted,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int STORE_BYTES = LED_CAPACITY * als_pkg::BYTES_PER_LED;
	localparam int AW = $clog2(STORE_BYTES);
	localparam int BW = $clog2(STORE_BYTES + 1);
	localparam int LW = $clog2(LED_CAPACITY + 1);

	als_pkg::timing_t   timing_q;
	als_pkg::wave_ctl_t wctl;
	als_pkg::wave_st_t  wst;

	logic [BW-1:0] fill_q;
	logic [LW-1:0] led_q;
	logic [LW-1:0] led_nx;
	logic [2:0]    pin_q;
	logic [7:0]    mask_q;
	logic          flush_pend_q;
	logic [1:0]    pend_q;
	logic [AW-1:0] wptr_q;
	logic [7:0]    red_q;
	logic [7:0]    blue_q;
	logic          done_q;

	logic          take;
	logic          ok;
	logic          room;
	logic          preload_go;
	logic          clear_go;
	logic          flush_go;
	logic [7:0]    level;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wave_addr;
	logic [7:0]    rd_data;

	assign cfg_ready = 1'b1;
	assign busy      = (pend_q != 2'd0) || flush_pend_q;
	assign done      = done_q;

	always_comb begin
		take  = start && !busy;
		room  = (BW+1)'(fill_q) + (BW+1)'(als_pkg::BYTES_PER_LED) <= (BW+1)'(STORE_BYTES);
		level = (wst.sending && !wst.low) ? (8'd1 << pin_q) : 8'd0;
		unique case (command)
			als_pkg::CMD_TICK:    ok = 1'b1;
			als_pkg::CMD_PRELOAD: ok = !wst.sending && room;
			als_pkg::CMD_CLEAR:   ok = !wst.sending;
			als_pkg::CMD_FLUSH:   ok = !wst.sending && (fill_q != '0);
			default:              ok = 1'b0;
		endcase
		preload_go = take && ok && (command == als_pkg::CMD_PRELOAD);
		clear_go   = take && ok && (command == als_pkg::CMD_CLEAR);
		flush_go   = take && ok && (command == als_pkg::CMD_FLUSH);
		wctl.tick  = take && (command == als_pkg::CMD_TICK);
		wctl.load  = flush_pend_q;

		led_nx = led_q;
		if (preload_go) begin
			led_nx = led_q + LW'(1);
		end else if (clear_go || wst.finish) begin
			led_nx = '0;
		end

		wr_en   = preload_go || (pend_q != 2'd0);
		wr_addr = preload_go ? fill_q[AW-1:0] : wptr_q;
		wr_data = preload_go ? green : ((pend_q == 2'd2) ? red_q : blue_q);

		rd_en   = flush_go || wst.rd_en;
		rd_addr = flush_go ? '0 : wave_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= '{zero_high: 8'd17, zero_low: 8'd38, one_high: 8'd34,
				one_low: 8'd29};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				als_pkg::REG_ZERO_HIGH: timing_q.zero_high <= cfg_data;
				als_pkg::REG_ZERO_LOW:  timing_q.zero_low  <= cfg_data;
				als_pkg::REG_ONE_HIGH:  timing_q.one_high  <= cfg_data;
				als_pkg::REG_ONE_LOW:   timing_q.one_low   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			led_q        <= '0;
			pin_q        <= 3'd0;
			mask_q       <= 8'd0;
			flush_pend_q <= 1'b0;
			pend_q       <= 2'd0;
			wptr_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			led_q        <= led_nx;
			flush_pend_q <= flush_go;
			done_q       <= (take && !flush_go) || flush_pend_q;
			if (preload_go) begin
				fill_q <= fill_q + BW'(als_pkg::BYTES_PER_LED);
				wptr_q <= fill_q[AW-1:0] + AW'(1);
				pend_q <= 2'd2;
			end else if (pend_q != 2'd0) begin
				wptr_q <= wptr_q + AW'(1);
				pend_q <= pend_q - 2'd1;
			end else if (clear_go || wst.finish) begin
				fill_q <= '0;
			end
			if (flush_go) begin
				pin_q  <= pin_index;
				mask_q <= mask_q | (8'd1 << pin_index);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (preload_go) begin
			red_q  <= red;
			blue_q <= blue;
		end
		if (flush_pend_q) begin
			line_levels  <= 8'd0;
			drive_enable <= mask_q;
			busy_res     <= 1'b1;
			led_count    <= 7'(led_q);
			accepted     <= 1'b1;
		end else if (take) begin
			line_levels  <= level;
			drive_enable <= mask_q;
			busy_res     <= wst.sending && !wst.finish;
			led_count    <= 7'(led_nx);
			accepted     <= ok;
		end
	end

	als_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	als_wave #(
		.STORE_BYTES(STORE_BYTES),
		.AW         (AW),
		.BW         (BW)
	) u_wave (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.timing (timing_q),
		.fill   (fill_q),
		.rd_data(rd_data),
		.st     (wst),
		.rd_addr(wave_addr)
	);

endmodule

`default_nettype wire

// File: rtl/core/als_store.sv
`default_nettype none

module als_store #(
	parameter int DEPTH = 192,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/als_wave.sv
`default_nettype none

module als_wave #(
	parameter int STORE_BYTES = 192,
	parameter int AW          = 8,
	parameter int BW          = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire als_pkg::wave_ctl_t  ctl,
	input  wire als_pkg::timing_t    timing,
	input  wire logic [BW-1:0]       fill,
	input  wire logic [7:0]          rd_data,
	output als_pkg::wave_st_t        st,
	output logic      [AW-1:0]       rd_addr
);

	logic          sending_q;
	logic          low_q;
	logic [7:0]    ticks_q;
	logic [2:0]    bit_q;
	logic [BW-1:0] byte_q;
	logic [7:0]    shift_q;

	logic          adv;
	logic          phase_end;
	logic          last_byte;
	logic [BW:0]   byte_inc;
	logic [BW:0]   byte_pre;

	always_comb begin
		adv       = ctl.tick && sending_q;
		phase_end = ticks_q <= 8'd1;
		byte_inc  = (BW+1)'(byte_q) + (BW+1)'(1);
		byte_pre  = (BW+1)'(byte_q) + (BW+1)'(2);
		last_byte = byte_inc >= (BW+1)'(fill);

		st.sending = sending_q;
		st.low     = low_q;
		st.finish  = adv && phase_end && low_q && (bit_q == 3'd0) && last_byte;
		st.rd_en   = 1'b0;
		rd_addr    = AW'(1);
		if (ctl.load) begin
			st.rd_en = 1'b1;
		end else if (adv && phase_end && low_q && (bit_q == 3'd0) && !last_byte) begin
			st.rd_en = byte_pre < (BW+1)'(STORE_BYTES);
			rd_addr  = byte_pre[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			low_q     <= 1'b0;
			ticks_q   <= 8'd0;
			bit_q     <= 3'd0;
			byte_q    <= '0;
		end else if (ctl.load) begin
			sending_q <= 1'b1;
			low_q     <= 1'b0;
			bit_q     <= als_pkg::LAST_BIT;
			byte_q    <= '0;
			ticks_q   <= als_pkg::phase_len(rd_data[7], 1'b0, timing);
		end else if (adv) begin
			if (!phase_end) begin
				ticks_q <= ticks_q - 8'd1;
			end else if (!low_q) begin
				low_q   <= 1'b1;
				ticks_q <= als_pkg::phase_len(shift_q[7], 1'b1, timing);
			end else begin
				low_q <= 1'b0;
				if (bit_q != 3'd0) begin
					bit_q   <= bit_q - 3'd1;
					ticks_q <= als_pkg::phase_len(shift_q[6], 1'b0, timing);
				end else if (last_byte) begin
					sending_q <= 1'b0;
					byte_q    <= '0;
					ticks_q   <= 8'd0;
				end else begin
					bit_q   <= als_pkg::LAST_BIT;
					byte_q  <= byte_inc[BW-1:0];
					ticks_q <= als_pkg::phase_len(rd_data[7], 1'b0, timing);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			shift_q <= rd_data;
		end else if (adv && phase_end && low_q) begin
			if (bit_q != 3'd0) begin
				shift_q <= {shift_q[6:0], 1'b0};
			end else begin
				shift_q <= rd_data;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/als_checker.sv
`default_nettype none

module als_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [7:0] line_levels,
	input wire logic [7:0] drive_enable,
	input wire logic       busy_res
);

	a_request_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request gave neither a result nor busy");

	a_busy_has_driver: assert property (@(posedge clk) disable iff (!arst_n)
		done && busy_res |-> drive_enable != 8'd0)
		else $error("sending with no driven line");

	a_one_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		done && line_levels != 8'd0 |-> $onehot(line_levels))
		else $error("more than one line high");

	a_high_line_driven: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (line_levels & ~drive_enable) == 8'd0)
		else $error("undriven line shown high");

endmodule

bind addressable_led_serializer als_checker u_als_checker (.*);

`default_nettype wire
